@@ hdl/cagn_pkg.sv @@
// ----------------------------------------------------------------------------
// cagn_pkg
// Shared types and constants for the class-aware greedy NMS block.
// ----------------------------------------------------------------------------
package cagn_pkg;

   localparam int POS_W = 6;   // cell index width, covers up to 64 cells

   typedef struct packed {
      logic               valid;
      logic               mark;    // suppressed by an earlier kept box
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic signed [15:0] right;
      logic signed [15:0] bottom;
      logic        [15:0] score;
      logic        [7:0]  cls;
   } box_type;

   typedef struct packed {
      logic             insert;   // sorted insertion of the new box
      logic             shift;    // move toward head, inject at pos
      logic [POS_W-1:0] pos;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_POP,
      S_CMP,
      S_WAIT,
      S_FLUSH
   } state_type;

   localparam logic ADDR_IOU_LIMIT = 1'b0;   // word index of iou_limit
   localparam logic [15:0] IOU_LIMIT_RESET = 16'd29491;

endpackage

@@ hdl/cagn_cell.sv @@
// ----------------------------------------------------------------------------
// cagn_cell
// One slot of the sorted box chain: sorted insert and shift toward head.
// ----------------------------------------------------------------------------
module cagn_cell #(
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cagn_pkg::cell_ctl_type ctl,
   input  cagn_pkg::box_type     new_box,
   input  cagn_pkg::box_type     inject_box,
   input  cagn_pkg::box_type     prev_box,
   input  logic                  prev_take,
   input  cagn_pkg::box_type     next_box,
   output cagn_pkg::box_type     box,
   output logic                  take
);
   import cagn_pkg::*;

   box_type box_ff, box_in;

   // ties go behind equal scores, which keeps arrival order
   assign take = !box_ff.valid || (box_ff.score < new_box.score);

   always_comb begin
      box_in = box_ff;
      if (ctl.insert) begin
         if (prev_take) begin
            box_in = prev_box;
         end else if (take) begin
            box_in = new_box;
         end
      end else if (ctl.shift) begin
         if (ctl.pos == POS_W'(IDX)) begin
            box_in = inject_box;
         end else begin
            box_in = next_box;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff.valid <= 1'b0;
         box_ff.mark  <= 1'b0;
      end else begin
         box_ff.valid <= box_in.valid;
         box_ff.mark  <= box_in.mark;
      end
      box_ff.left   <= box_in.left;
      box_ff.top    <= box_in.top;
      box_ff.right  <= box_in.right;
      box_ff.bottom <= box_in.bottom;
      box_ff.score  <= box_in.score;
      box_ff.cls    <= box_in.cls;
   end

   assign box = box_ff;

endmodule

@@ hdl/cagn_iou.sv @@
// ----------------------------------------------------------------------------
// cagn_iou
// Five-stage overlap test: inter * 65536 > limit * union, no division.
// ----------------------------------------------------------------------------
module cagn_iou (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cagn_pkg::box_type a,
   input  cagn_pkg::box_type b,
   input  logic [15:0]       limit,
   output logic              done,
   output logic              hit
);
   import cagn_pkg::*;

   logic [4:0]  v_ff;
   logic [15:0] iw_ff, ih_ff, aw_ff, ah_ff, bw_ff, bh_ff;
   logic [15:0] bw2_ff, bh2_ff;
   logic [31:0] inter2_ff, area_a2_ff;
   logic [31:0] inter3_ff, area_a3_ff, area_b3_ff;
   logic [31:0] inter4_ff;
   logic [32:0] uni4_ff;
   logic [47:0] inter5_ff;
   logic [48:0] prod5_ff;

   function automatic logic [15:0] span(input logic signed [15:0] lo,
                                        input logic signed [15:0] hi);
      logic signed [16:0] d;
      d = 17'(hi) - 17'(lo);
      return d[16] ? 16'd0 : d[15:0];
   endfunction

   logic signed [15:0] ix1, iy1, ix2, iy2;
   assign ix1 = (a.left   > b.left)   ? a.left   : b.left;
   assign iy1 = (a.top    > b.top)    ? a.top    : b.top;
   assign ix2 = (a.right  < b.right)  ? a.right  : b.right;
   assign iy2 = (a.bottom < b.bottom) ? a.bottom : b.bottom;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[3:0], start};
      end
      iw_ff      <= span(ix1, ix2);
      ih_ff      <= span(iy1, iy2);
      aw_ff      <= span(a.left, a.right);
      ah_ff      <= span(a.top, a.bottom);
      bw_ff      <= span(b.left, b.right);
      bh_ff      <= span(b.top, b.bottom);
      inter2_ff  <= iw_ff * ih_ff;
      area_a2_ff <= aw_ff * ah_ff;
      bw2_ff     <= bw_ff;
      bh2_ff     <= bh_ff;
      inter3_ff  <= inter2_ff;
      area_a3_ff <= area_a2_ff;
      area_b3_ff <= bw2_ff * bh2_ff;
      inter4_ff  <= inter3_ff;
      uni4_ff    <= 33'(area_a3_ff) + 33'(area_b3_ff) - 33'(inter3_ff);
      inter5_ff  <= {inter4_ff, 16'd0};
      prod5_ff   <= 49'(limit) * 49'(uni4_ff);
   end

   assign done = v_ff[4];
   assign hit  = 49'(inter5_ff) > prod5_ff;

endmodule

@@ hdl/class_aware_greedy_nms.sv @@
// Load: one item per cycle in the load state; each box is placed in sorted
// position as it is accepted. NMS: each kept box is compared with every remaining
// box in turn (shared IoU pipeline, 5 stages); suppressed boxes are only popped.
// Results appear one kept box behind the walk, so last_result is known.
// Synchronous active-high reset empties the chain and sets iou_limit to 29491.
// ----------------------------------------------------------------------------
// class_aware_greedy_nms
// Score-sorted cell chain with a single IoU unit walking it greedily.
// ----------------------------------------------------------------------------
module class_aware_greedy_nms #(
   parameter int MAX_BOXES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_left_edge,
   input  logic signed [15:0] req_top_edge,
   input  logic signed [15:0] req_right_edge,
   input  logic signed [15:0] req_bottom_edge,
   input  logic        [15:0] req_confidence,
   input  logic        [7:0]  req_category,
   input  logic               req_present,
   input  logic               req_end_of_set,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_kept_left,
   output logic signed [15:0] rsp_kept_top,
   output logic signed [15:0] rsp_kept_right,
   output logic signed [15:0] rsp_kept_bottom,
   output logic        [15:0] rsp_kept_score,
   output logic        [7:0]  rsp_kept_class,
   output logic               rsp_box_valid,
   output logic               rsp_last_result,
   output logic               rsp_overflowed,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import cagn_pkg::*;

   localparam int CNT_W = $clog2(MAX_BOXES + 1);

   state_type      state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, rem_ff, rem_in, k_ff, k_in;
   logic           ovf_ff, ovf_in, set_ovf_ff, set_ovf_in;
   box_type        pend_ff, pend_in;
   logic           pend_v_ff, pend_v_in;
   logic           rsp_v_ff, rsp_v_in;
   box_type        out_ff, out_in;
   logic           out_last_ff, out_last_in, out_ovf_ff, out_ovf_in;
   logic           out_bv_ff, out_bv_in;
   logic [15:0]    limit_ff;

   cell_ctl_type   ctl;
   box_type        new_box, inject_box, head;
   box_type        cell_box [MAX_BOXES];
   logic           cell_take [MAX_BOXES];
   logic           acc_req, full, out_free, iou_start, iou_done, iou_hit, sup;
   logic [CNT_W-1:0] rem_m1;

   // config port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == ADDR_IOU_LIMIT) ? {16'd0, limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= IOU_LIMIT_RESET;
      end else if (psel && penable && pwrite && paddr[2] == ADDR_IOU_LIMIT) begin
         limit_ff <= pwdata[15:0];
      end
   end

   assign req_ready = (state_ff == S_LOAD);
   assign acc_req   = req_valid && req_ready;
   assign full      = (cnt_ff == CNT_W'(MAX_BOXES));
   assign out_free  = !rsp_v_ff || rsp_ready;
   assign head      = cell_box[0];
   assign rem_m1    = rem_ff - CNT_W'(1);
   assign sup       = iou_hit && (head.cls == pend_ff.cls);

   always_comb begin
      new_box        = '0;
      new_box.valid  = 1'b1;
      new_box.left   = req_left_edge;
      new_box.top    = req_top_edge;
      new_box.right  = req_right_edge;
      new_box.bottom = req_bottom_edge;
      new_box.score  = req_confidence;
      new_box.cls    = req_category;
   end

   // cell chain
   for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
      box_type prev_b, next_b;
      logic    prev_t;
      if (i == 0) begin : g_first
         assign prev_b = '0;
         assign prev_t = 1'b0;
      end else begin : g_mid
         assign prev_b = cell_box[i-1];
         assign prev_t = cell_take[i-1];
      end
      if (i == MAX_BOXES - 1) begin : g_last
         assign next_b = '0;
      end else begin : g_inner
         assign next_b = cell_box[i+1];
      end
      cagn_cell #(.IDX(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_box    (new_box),
         .inject_box (inject_box),
         .prev_box   (prev_b),
         .prev_take  (prev_t),
         .next_box   (next_b),
         .box        (cell_box[i]),
         .take       (cell_take[i])
      );
   end

   cagn_iou u_iou (
      .clock (clock),
      .reset (reset),
      .start (iou_start),
      .a     (pend_ff),
      .b     (head),
      .limit (limit_ff),
      .done  (iou_done),
      .hit   (iou_hit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:  if (acc_req && req_end_of_set) state_in = S_POP;
         S_POP: begin
            if (rem_ff == '0) begin
               state_in = S_FLUSH;
            end else if (!head.mark && out_free) begin
               state_in = S_CMP;
            end
         end
         S_CMP:   state_in = (k_ff == '0) ? S_POP : S_WAIT;
         S_WAIT:  if (iou_done) state_in = S_CMP;
         S_FLUSH: if (out_free) state_in = S_LOAD;
         default: state_in = S_LOAD;
      endcase
   end

   // chain and IoU control
   always_comb begin
      ctl        = '0;
      ctl.pos    = POS_W'(rem_m1);
      ctl.insert = acc_req && req_present && !full;
      inject_box = '0;
      iou_start  = (state_ff == S_CMP) && (k_ff != '0);
      if (state_ff == S_POP && rem_ff != '0 && (head.mark || out_free)) begin
         ctl.shift = 1'b1;   // pop head, empty slot at tail
      end
      if (state_ff == S_WAIT && iou_done) begin
         ctl.shift       = 1'b1;   // rotate head to tail with its verdict
         inject_box      = head;
         inject_box.mark = head.mark || sup;
      end
   end

   // datapath
   always_comb begin
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      set_ovf_in  = set_ovf_ff;
      rem_in      = rem_ff;
      k_in        = k_ff;
      pend_in     = pend_ff;
      pend_v_in   = pend_v_ff;
      rsp_v_in    = rsp_v_ff && !rsp_ready;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_ovf_in  = out_ovf_ff;
      out_bv_in   = out_bv_ff;
      case (state_ff)
         S_LOAD: begin
            if (acc_req) begin
               if (req_present) begin
                  if (!full) cnt_in = cnt_ff + CNT_W'(1);
                  else       ovf_in = 1'b1;
               end
               if (req_end_of_set) begin
                  set_ovf_in = ovf_ff || (req_present && full);
                  rem_in     = cnt_ff + CNT_W'(req_present && !full);
                  cnt_in     = '0;
                  ovf_in     = 1'b0;
               end
            end
         end
         S_POP: begin
            if (rem_ff != '0) begin
               if (head.mark) begin
                  rem_in = rem_m1;
               end else if (out_free) begin
                  if (pend_v_ff) begin
                     out_in      = pend_ff;
                     out_bv_in   = 1'b1;
                     out_last_in = 1'b0;
                     out_ovf_in  = set_ovf_ff;
                     rsp_v_in    = 1'b1;
                  end
                  pend_in   = head;
                  pend_v_in = 1'b1;
                  rem_in    = rem_m1;
                  k_in      = rem_m1;
               end
            end
         end
         S_WAIT: begin
            if (iou_done) k_in = k_ff - CNT_W'(1);
         end
         S_FLUSH: begin
            if (out_free) begin
               out_in      = pend_v_ff ? pend_ff : '0;
               out_bv_in   = pend_v_ff;
               out_last_in = 1'b1;
               out_ovf_in  = set_ovf_ff;
               rsp_v_in    = 1'b1;
               pend_v_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
         set_ovf_ff <= 1'b0;
         rem_ff     <= '0;
         k_ff       <= '0;
         pend_v_ff  <= 1'b0;
         rsp_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
         set_ovf_ff <= set_ovf_in;
         rem_ff     <= rem_in;
         k_ff       <= k_in;
         pend_v_ff  <= pend_v_in;
         rsp_v_ff   <= rsp_v_in;
      end
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
      out_bv_ff   <= out_bv_in;
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_kept_left   = out_ff.left;
   assign rsp_kept_top    = out_ff.top;
   assign rsp_kept_right  = out_ff.right;
   assign rsp_kept_bottom = out_ff.bottom;
   assign rsp_kept_score  = out_ff.score;
   assign rsp_kept_class  = out_ff.cls;
   assign rsp_box_valid   = out_bv_ff;
   assign rsp_last_result = out_last_ff;
   assign rsp_overflowed  = out_ovf_ff;

`ifndef SYNTHESIS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      iou_done |-> state_ff == S_WAIT)
      else $error("IoU result outside wait state");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_BOXES) && rem_ff <= CNT_W'(MAX_BOXES))
      else $error("box count beyond capacity");
   a_ref_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP || state_ff == S_WAIT) |-> pend_v_ff)
      else $error("compare without a kept reference box");
`endif

endmodule
